// ===== src/pwwa_pkg.sv =====
`default_nettype none
package pwwa_pkg;

	localparam int MAX_BINS    = 1024;
	localparam int RATE_BITS   = 24;
	localparam int WEIGHT_BITS = 24;

	localparam int ADDR_BITS  = $clog2(MAX_BINS);
	localparam int BIN_BITS   = ADDR_BITS + 1;
	localparam int HW_BITS    = 10;
	localparam int PSUM_BITS  = RATE_BITS + WEIGHT_BITS + ADDR_BITS;
	localparam int WSUM_BITS  = WEIGHT_BITS + ADDR_BITS;
	localparam int STEP_BITS  = $clog2(RATE_BITS);
	localparam int OP_BITS    = 2;
	localparam int CIDX_BITS  = 2;
	localparam int CDATA_BITS = BIN_BITS;

	// operation codes
	localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_BITS-1:0] OP_QUERY   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_RESTART = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_BITS-1:0] CFG_HALF_WINDOW = 2'd0;
	localparam logic [CIDX_BITS-1:0] CFG_FIRST_BIN   = 2'd1;
	localparam logic [CIDX_BITS-1:0] CFG_LAST_BIN    = 2'd2;

	localparam logic [HW_BITS-1:0]  HALF_WINDOW_RST = HW_BITS'(7 * 27);
	localparam logic [BIN_BITS-1:0] FIRST_BIN_RST   = BIN_BITS'(1);
	localparam logic [BIN_BITS-1:0] LAST_BIN_RST    = BIN_BITS'(MAX_BINS);

	// one row of prefix sums
	typedef struct packed {
		logic [PSUM_BITS-1:0] prod_a;
		logic [PSUM_BITS-1:0] prod_b;
		logic [WSUM_BITS-1:0] wgt_a;
		logic [WSUM_BITS-1:0] wgt_b;
		logic [BIN_BITS-1:0]  count;
	} psum_t;

endpackage
`default_nettype wire

// ===== src/paired_weighted_window_average.sv =====
`default_nettype none
// Paired weighted window average. Load transactions (operation 0) append one
// bin, in order from bin 1, and store prefix sums of rate*weight, weight and
// qualifying count for both series in an on-chip table of MAX_BINS rows; a bin
// qualifies when both rates and both weights are nonzero, and loads beyond
// capacity are dropped. Restart (operation 2) empties the series;
// operation 3 is ignored. A query transaction (operation 1) returns the
// weighted averages of the window of half_window bins either side of query_bin,
// clipped to [first_bin, last_bin] and to the loaded bins, truncated to Q8.16
// and saturated, or valid_res = 0 with zero payload when nothing counts. The
// block works on one transaction at a time: a load goes through accept,
// multiply and table write, a restart is done as it is accepted, and a valid
// query goes through range check, two table reads, subtract, then two
// divisions on one shared bit-serial divider that has a setup step and
// produces one quotient bit per cycle, then the output write; a query that is
// rejected early skips ahead to the output write. A finished result
// waits in the output register while the next transaction is taken in; the
// block only holds when a second result is ready before the first is taken.
// Configuration writes are taken on any cycle but belong between transactions.
module paired_weighted_window_average
	import pwwa_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	// configuration
	input  wire                    cfg_write,
	input  wire  [CIDX_BITS-1:0]   cfg_index,
	input  wire  [CDATA_BITS-1:0]  cfg_data,
	// input channel
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [OP_BITS-1:0]     operation,
	input  wire  [BIN_BITS-1:0]    query_bin,
	input  wire  [RATE_BITS-1:0]   rate_a,
	input  wire  [RATE_BITS-1:0]   rate_b,
	input  wire  [WEIGHT_BITS-1:0] weight_a,
	input  wire  [WEIGHT_BITS-1:0] weight_b,
	// output channel
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [BIN_BITS-1:0]    result_bin,
	output logic [RATE_BITS-1:0]   average_a,
	output logic [RATE_BITS-1:0]   average_b,
	output logic                   valid_res,
	output logic [BIN_BITS-1:0]    contributors
);

	localparam int ST_BITS = 4;
	localparam logic [ST_BITS-1:0] S_IDLE    = 4'd0;
	localparam logic [ST_BITS-1:0] S_LDMUL   = 4'd1;
	localparam logic [ST_BITS-1:0] S_LDWR    = 4'd2;
	localparam logic [ST_BITS-1:0] S_QRANGE  = 4'd3;
	localparam logic [ST_BITS-1:0] S_QHI     = 4'd4;
	localparam logic [ST_BITS-1:0] S_QLO     = 4'd5;
	localparam logic [ST_BITS-1:0] S_QSUB    = 4'd6;
	localparam logic [ST_BITS-1:0] S_DIVINIT = 4'd7;
	localparam logic [ST_BITS-1:0] S_DIV     = 4'd8;
	localparam logic [ST_BITS-1:0] S_DONE    = 4'd9;

	localparam int WB = BIN_BITS + 1;   // window bounds can run past the bin range
	localparam int PROD_BITS = RATE_BITS + WEIGHT_BITS;
	localparam int HIGH_BITS = PSUM_BITS - RATE_BITS;   // numerator bits above the quotient
	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(RATE_BITS - 1);

	// configuration
	logic [HW_BITS-1:0]  half_window_q;
	logic [BIN_BITS-1:0] first_bin_q;
	logic [BIN_BITS-1:0] last_bin_q;

	// control
	logic [ST_BITS-1:0]  state_q;
	logic [BIN_BITS-1:0] loaded_q;
	logic                out_valid_q;
	logic                lo_gt1_q;
	logic                ok_q;
	logic                sel_b_q;
	logic [STEP_BITS-1:0] step_q;

	// payload
	logic [BIN_BITS-1:0]    bin_q;
	logic [RATE_BITS-1:0]   rate_a_q, rate_b_q;
	logic [WEIGHT_BITS-1:0] weight_a_q, weight_b_q;
	logic [PROD_BITS-1:0]   prod_a_q, prod_b_q;
	logic                   qual_q;
	psum_t                  run_q;
	psum_t                  acc_q;
	psum_t                  rd_data_q;
	logic [ADDR_BITS-1:0]   rd_addr_q;
	logic [ADDR_BITS-1:0]   lo_addr_q;
	logic [WSUM_BITS-1:0]   rem_q;
	logic [RATE_BITS-1:0]   sh_q;
	logic                   sat_q;
	logic [RATE_BITS-1:0]   avg_a_q, avg_b_q;

	logic [BIN_BITS-1:0]    result_bin_q;
	logic [RATE_BITS-1:0]   average_a_q, average_b_q;
	logic                   valid_res_q;
	logic [BIN_BITS-1:0]    contributors_q;

	psum_t mem [MAX_BINS];

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_bin   = result_bin_q;
	assign average_a    = average_a_q;
	assign average_b    = average_b_q;
	assign valid_res    = valid_res_q;
	assign contributors = contributors_q;

	logic in_acc;
	logic out_free;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------
	// Window bounds for a query
	// ---------------------------------------------------------------
	logic [WB-1:0] b_w, hw_w, first_w, last_w, loaded_w;
	logic [WB-1:0] lo_a, lo_w, hi_a, hi_b, hi_w;
	logic          range_ok;
	logic [WB-1:0] hi_m1, lo_m2;

	always_comb begin
		b_w      = WB'(bin_q);
		hw_w     = WB'(half_window_q);
		first_w  = WB'(first_bin_q);
		last_w   = WB'(last_bin_q);
		loaded_w = WB'(loaded_q);
		lo_a     = (b_w > hw_w) ? (b_w - hw_w) : WB'(1);
		lo_w     = (lo_a < first_w) ? first_w : lo_a;
		hi_a     = b_w + hw_w;
		hi_b     = (hi_a > loaded_w) ? loaded_w : hi_a;
		hi_w     = (hi_b > last_w) ? last_w : hi_b;
		range_ok = (b_w != '0) && (b_w <= loaded_w) && (b_w >= first_w)
			&& (b_w <= last_w) && (lo_w <= hi_w);
		hi_m1    = hi_w - WB'(1);
		lo_m2    = lo_w - WB'(2);
	end

	// ---------------------------------------------------------------
	// Load: add this bin's contribution to the running totals
	// ---------------------------------------------------------------
	psum_t run_base;
	psum_t run_next;
	always_comb begin
		// the first bin after reset or restart starts from zero
		run_base = (loaded_q == '0) ? '0 : run_q;
		run_next = run_base;
		if (qual_q) begin
			run_next.prod_a = run_base.prod_a + PSUM_BITS'(prod_a_q);
			run_next.prod_b = run_base.prod_b + PSUM_BITS'(prod_b_q);
			run_next.wgt_a  = run_base.wgt_a + WSUM_BITS'(weight_a_q);
			run_next.wgt_b  = run_base.wgt_b + WSUM_BITS'(weight_b_q);
			run_next.count  = run_base.count + BIN_BITS'(1);
		end
	end

	// ---------------------------------------------------------------
	// Query: window sums as difference of two prefix rows
	// ---------------------------------------------------------------
	psum_t win;
	always_comb begin
		win = acc_q;
		if (lo_gt1_q) begin
			win.prod_a = acc_q.prod_a - rd_data_q.prod_a;
			win.prod_b = acc_q.prod_b - rd_data_q.prod_b;
			win.wgt_a  = acc_q.wgt_a - rd_data_q.wgt_a;
			win.wgt_b  = acc_q.wgt_b - rd_data_q.wgt_b;
			win.count  = acc_q.count - rd_data_q.count;
		end
	end

	// ---------------------------------------------------------------
	// Bit-serial restoring divider, one quotient bit per cycle.
	// The remainder starts with the numerator bits above the quotient
	// range; if those already reach the divisor the quotient saturates.
	// ---------------------------------------------------------------
	logic [PSUM_BITS-1:0] div_num;
	logic [WSUM_BITS-1:0] div_den;
	logic [WSUM_BITS:0]   trial;
	logic                 qbit;
	logic [WSUM_BITS:0]   trial_diff;
	logic [RATE_BITS-1:0] sh_next;

	always_comb begin
		div_num    = sel_b_q ? acc_q.prod_b : acc_q.prod_a;
		div_den    = sel_b_q ? acc_q.wgt_b : acc_q.wgt_a;
		trial      = {rem_q, sh_q[RATE_BITS-1]};
		qbit       = (trial >= {1'b0, div_den});
		trial_diff = trial - {1'b0, div_den};
		sh_next    = {sh_q[RATE_BITS-2:0], qbit};
	end

	// ---------------------------------------------------------------
	// Prefix table: one write port, one registered read port
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == S_LDWR) begin
			mem[loaded_q[ADDR_BITS-1:0]] <= run_next;
		end
		if (state_q == S_QHI || state_q == S_QLO) begin
			rd_data_q <= mem[rd_addr_q];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= HALF_WINDOW_RST;
			first_bin_q   <= FIRST_BIN_RST;
			last_bin_q    <= LAST_BIN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HALF_WINDOW: half_window_q <= cfg_data[HW_BITS-1:0];
				CFG_FIRST_BIN:   first_bin_q   <= cfg_data;
				CFG_LAST_BIN:    last_bin_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			out_valid_q <= 1'b0;
			lo_gt1_q    <= 1'b0;
			ok_q        <= 1'b0;
			sel_b_q     <= 1'b0;
			step_q      <= '0;
		end else begin
			// raise valid with a new result, drop it once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (operation)
							OP_LOAD:    state_q <= S_LDMUL;
							OP_QUERY:   state_q <= S_QRANGE;
							OP_RESTART: loaded_q <= '0;
							default:    ;
						endcase
					end
				end
				S_LDMUL: begin
					// table full: drop the load
					state_q <= (loaded_q == BIN_BITS'(MAX_BINS)) ? S_IDLE : S_LDWR;
				end
				S_LDWR: begin
					loaded_q <= loaded_q + BIN_BITS'(1);
					state_q  <= S_IDLE;
				end
				S_QRANGE: begin
					lo_gt1_q <= (lo_w > WB'(1));
					ok_q     <= 1'b0;
					state_q  <= range_ok ? S_QHI : S_DONE;
				end
				S_QHI: state_q <= S_QLO;
				S_QLO: state_q <= S_QSUB;
				S_QSUB: begin
					sel_b_q <= 1'b0;
					if (win.count != '0 && win.wgt_a != '0 && win.wgt_b != '0) begin
						ok_q    <= 1'b1;
						state_q <= S_DIVINIT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIVINIT: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == LAST_STEP) begin
						sel_b_q <= 1'b1;
						state_q <= sel_b_q ? S_DONE : S_DIVINIT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bin_q      <= query_bin;
			rate_a_q   <= rate_a;
			rate_b_q   <= rate_b;
			weight_a_q <= weight_a;
			weight_b_q <= weight_b;
		end
		if (in_acc && operation == OP_RESTART) begin
			run_q <= '0;
		end
		if (state_q == S_LDMUL) begin
			prod_a_q <= PROD_BITS'(rate_a_q) * PROD_BITS'(weight_a_q);
			prod_b_q <= PROD_BITS'(rate_b_q) * PROD_BITS'(weight_b_q);
			qual_q   <= (rate_a_q != '0) && (rate_b_q != '0)
				&& (weight_a_q != '0) && (weight_b_q != '0);
		end
		if (state_q == S_LDWR) begin
			run_q <= run_next;
		end
		if (state_q == S_QRANGE) begin
			rd_addr_q <= hi_m1[ADDR_BITS-1:0];
			lo_addr_q <= lo_m2[ADDR_BITS-1:0];
		end
		if (state_q == S_QHI) begin
			rd_addr_q <= lo_addr_q;
		end
		if (state_q == S_QLO) begin
			acc_q <= rd_data_q;
		end
		if (state_q == S_QSUB) begin
			acc_q <= win;
		end
		if (state_q == S_DIVINIT) begin
			rem_q <= div_num[PSUM_BITS-1 -: HIGH_BITS];
			sh_q  <= div_num[RATE_BITS-1:0];
			sat_q <= (div_num[PSUM_BITS-1 -: HIGH_BITS] >= div_den);
		end
		if (state_q == S_DIV) begin
			rem_q <= qbit ? trial_diff[WSUM_BITS-1:0] : trial[WSUM_BITS-1:0];
			sh_q  <= sh_next;
			if (step_q == LAST_STEP) begin
				if (sel_b_q) begin
					avg_b_q <= sat_q ? '1 : sh_next;
				end else begin
					avg_a_q <= sat_q ? '1 : sh_next;
				end
			end
		end
		if (state_q == S_DONE && out_free) begin
			result_bin_q   <= bin_q;
			valid_res_q    <= ok_q;
			average_a_q    <= ok_q ? avg_a_q : '0;
			average_b_q    <= ok_q ? avg_b_q : '0;
			contributors_q <= ok_q ? acc_q.count : '0;
		end
	end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pwwa_pkg::*;

	// Operation 3 has no name in the package; the block must ignore it.
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

	localparam logic [RATE_BITS-1:0]   FULL_RATE   = '1;
	localparam logic [WEIGHT_BITS-1:0] FULL_WEIGHT = '1;
	localparam longint unsigned        RATE_CEIL   = (64'd1 << RATE_BITS) - 64'd1;

	// Let this many cycles go by after the last result before touching the
	// registers, and again at the end to catch stray results.
	localparam int SETTLE_CYCLES   = 100;
	// Cycles without a single transaction on either channel before giving up.
	// The longest legal quiet stretch is the receiver hold-off below plus one
	// query, so this leaves a wide margin.
	localparam int WATCHDOG_LIMIT  = 6000;
	localparam int HOLD_CYCLES     = 500;
	localparam int PHASE_ITEMS     = 4;
	localparam int FILL_LOADS      = MAX_BINS + 2;
	localparam int MAX_REPORTS     = 10;

	// One input transaction, field for field as on the ports.
	typedef struct packed {
		logic [OP_BITS-1:0]     op;
		logic [BIN_BITS-1:0]    bin;
		logic [RATE_BITS-1:0]   ra;
		logic [RATE_BITS-1:0]   rb;
		logic [WEIGHT_BITS-1:0] wa;
		logic [WEIGHT_BITS-1:0] wb;
	} bin_item_t;

	// One output transaction.
	typedef struct packed {
		logic [BIN_BITS-1:0]  bin;
		logic [RATE_BITS-1:0] avg_a;
		logic [RATE_BITS-1:0] avg_b;
		logic                 ok;
		logic [BIN_BITS-1:0]  cnt;
	} answer_t;

	// Directed row: when typed is set the answer is written out by hand,
	// otherwise it comes from the window predictor.
	typedef struct packed {
		bin_item_t item;
		logic      typed;
		answer_t   answer;
	} script_row_t;

	localparam answer_t NO_ANSWER = '0;
	localparam int SCRIPT_ROWS = 24;

	script_row_t script [SCRIPT_ROWS] = '{
		// query with nothing loaded
		'{'{OP_QUERY, 11'd1, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
			'{11'd1, 24'd0, 24'd0, 1'b0, 11'd0}},
		// query bin zero, ignored fields at their maximum
		'{'{OP_QUERY, 11'd0, FULL_RATE, FULL_RATE, FULL_WEIGHT, FULL_WEIGHT}, 1'b1,
			'{11'd0, 24'd0, 24'd0, 1'b0, 11'd0}},
		// unused operation, every field high
		'{'{OP_UNUSED, 11'h7FF, FULL_RATE, FULL_RATE, FULL_WEIGHT, FULL_WEIGHT}, 1'b0,
			NO_ANSWER},
		// bin 1: everything at the top of its range
		'{'{OP_LOAD, 11'h7FF, FULL_RATE, FULL_RATE, FULL_WEIGHT, FULL_WEIGHT}, 1'b0,
			NO_ANSWER},
		// a lone full-scale bin averages to itself
		'{'{OP_QUERY, 11'd1, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
			'{11'd1, FULL_RATE, FULL_RATE, 1'b1, 11'd1}},
		// bins 2 and 3 do not qualify: one zero rate, one zero weight
		'{'{OP_LOAD, 11'd0, 24'd0, FULL_RATE, FULL_WEIGHT, FULL_WEIGHT}, 1'b0, NO_ANSWER},
		'{'{OP_LOAD, 11'd0, FULL_RATE, FULL_RATE, FULL_WEIGHT, 24'd0}, 1'b0, NO_ANSWER},
		// bin 4: smallest qualifying values
		'{'{OP_LOAD, 11'd0, 24'd1, 24'd1, 24'd1, 24'd1}, 1'b0, NO_ANSWER},
		'{'{OP_QUERY, 11'd2, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, NO_ANSWER},
		// just past the loaded bins, and the largest encodable bin
		'{'{OP_QUERY, 11'd5, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
			'{11'd5, 24'd0, 24'd0, 1'b0, 11'd0}},
		'{'{OP_QUERY, 11'h7FF, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
			'{11'h7FF, 24'd0, 24'd0, 1'b0, 11'd0}},
		// zero rate b, then zero weight a
		'{'{OP_LOAD, 11'd0, 24'd1, 24'd0, 24'd1, 24'd1}, 1'b0, NO_ANSWER},
		'{'{OP_LOAD, 11'd0, 24'd1, 24'd1, 24'd0, 24'd1}, 1'b0, NO_ANSWER},
		'{'{OP_LOAD, 11'd0, 24'h123456, 24'hABCDEF, 24'h000100, 24'hFEDCBA}, 1'b0,
			NO_ANSWER},
		'{'{OP_QUERY, 11'd4, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, NO_ANSWER},
		'{'{OP_QUERY, 11'd1024, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
			'{11'd1024, 24'd0, 24'd0, 1'b0, 11'd0}},
		// restart empties the series
		'{'{OP_RESTART, 11'h7FF, FULL_RATE, FULL_RATE, FULL_WEIGHT, FULL_WEIGHT}, 1'b0,
			NO_ANSWER},
		'{'{OP_QUERY, 11'd1, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
			'{11'd1, 24'd0, 24'd0, 1'b0, 11'd0}},
		// lopsided series after the restart
		'{'{OP_LOAD, 11'd0, 24'd1, FULL_RATE, FULL_WEIGHT, 24'd1}, 1'b0, NO_ANSWER},
		'{'{OP_LOAD, 11'd0, 24'h800000, 24'h010000, 24'h7FFFFF, 24'h000001}, 1'b0,
			NO_ANSWER},
		'{'{OP_QUERY, 11'd1, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, NO_ANSWER},
		'{'{OP_QUERY, 11'd2, FULL_RATE, 24'd0, FULL_WEIGHT, 24'd0}, 1'b0, NO_ANSWER},
		'{'{OP_UNUSED, 11'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, NO_ANSWER},
		'{'{OP_QUERY, 11'd2, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, NO_ANSWER}
	};

	// Register settings of the random phases: half window, first bin, last bin.
	localparam int PHASES = 12;
	int phase_hw    [PHASES] = '{189, 0, 1023, 3, 1, 10, 25, 2, 50, 1023, 6, 0};
	int phase_first [PHASES] = '{1, 1, 1, 5, 1, 40, 1, 20, 1, 1024, 2, 1};
	int phase_last  [PHASES] = '{1024, 1024, 1024, 40, 1, 30, 1024, 1024, 64, 1, 1023, 1};

	// Settings used while the table is full.
	localparam int FULL_SETTINGS = 4;
	int full_hw    [FULL_SETTINGS] = '{1023, 7, 0, 200};
	int full_first [FULL_SETTINGS] = '{1, 1024, 1000, 900};
	int full_last  [FULL_SETTINGS] = '{1024, 1024, 1024, 1010};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CIDX_BITS-1:0]   cfg_index;
	logic [CDATA_BITS-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [OP_BITS-1:0]     operation;
	logic [BIN_BITS-1:0]    query_bin;
	logic [RATE_BITS-1:0]   rate_a;
	logic [RATE_BITS-1:0]   rate_b;
	logic [WEIGHT_BITS-1:0] weight_a;
	logic [WEIGHT_BITS-1:0] weight_b;
	logic                   out_valid;
	logic                   out_stall;
	logic [BIN_BITS-1:0]    result_bin;
	logic [RATE_BITS-1:0]   average_a;
	logic [RATE_BITS-1:0]   average_b;
	logic                   valid_res;
	logic [BIN_BITS-1:0]    contributors;

	paired_weighted_window_average dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.query_bin    (query_bin),
		.rate_a       (rate_a),
		.rate_b       (rate_b),
		.weight_a     (weight_a),
		.weight_b     (weight_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_bin   (result_bin),
		.average_a    (average_a),
		.average_b    (average_b),
		.valid_res    (valid_res),
		.contributors (contributors)
	);

	// Predictor state: prefix sums over qualifying bins 1..k kept at entry k-1,
	// the number of loaded bins and a copy of the three registers.
	longint unsigned rw_prefix_a [MAX_BINS];
	longint unsigned rw_prefix_b [MAX_BINS];
	longint unsigned w_prefix_a  [MAX_BINS];
	longint unsigned w_prefix_b  [MAX_BINS];
	int unsigned     n_prefix    [MAX_BINS];
	int              bins_loaded;
	int              hw_cfg;
	int              first_cfg;
	int              last_cfg;

	answer_t expected_answers [$];
	int      mismatches;
	int      send_gap_pct;
	int      recv_gap_pct;
	int      hold_requests;
	int      quiet_cycles;
	answer_t got_answer;
	answer_t want_answer;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Truncated quotient, saturated to the rate range; nothing over zero is 0.
	function automatic logic [RATE_BITS-1:0] clip_quotient(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		if (den == 0)
			return '0;
		q = num / den;
		return (q > RATE_CEIL) ? FULL_RATE : q[RATE_BITS-1:0];
	endfunction

	// Weighted averages over the window around qbin, clipped to the range
	// registers and to the loaded bins.
	function automatic answer_t window_answer(input logic [BIN_BITS-1:0] qbin);
		answer_t         a;
		int              b;
		int              lo;
		int              hi;
		longint unsigned pa;
		longint unsigned pb;
		longint unsigned sa;
		longint unsigned sb;
		int unsigned     n;
		a = '0;
		a.bin = qbin;
		b = int'(qbin);
		if (b >= 1 && b <= bins_loaded && b >= first_cfg && b <= last_cfg) begin
			lo = (b > hw_cfg) ? b - hw_cfg : 1;
			hi = b + hw_cfg;
			if (lo < first_cfg)
				lo = first_cfg;
			if (hi > bins_loaded)
				hi = bins_loaded;
			if (hi > last_cfg)
				hi = last_cfg;
			if (lo <= hi) begin
				pa = rw_prefix_a[hi-1];
				pb = rw_prefix_b[hi-1];
				sa = w_prefix_a[hi-1];
				sb = w_prefix_b[hi-1];
				n  = n_prefix[hi-1];
				if (lo > 1) begin
					pa -= rw_prefix_a[lo-2];
					pb -= rw_prefix_b[lo-2];
					sa -= w_prefix_a[lo-2];
					sb -= w_prefix_b[lo-2];
					n  -= n_prefix[lo-2];
				end
				if (n > 0 && sa != 0 && sb != 0) begin
					a.ok    = 1'b1;
					a.cnt   = BIN_BITS'(n);
					a.avg_a = clip_quotient(pa, sa);
					a.avg_b = clip_quotient(pb, sb);
				end
			end
		end
		return a;
	endfunction

	// Advance the predictor by one accepted transaction; has is set when
	// the transaction produces an answer.
	function automatic void predict(input bin_item_t it, output logic has, output answer_t ans);
		longint unsigned pa;
		longint unsigned pb;
		longint unsigned sa;
		longint unsigned sb;
		int unsigned     n;
		int              k;
		has = 1'b0;
		ans = '0;
		case (it.op)
			OP_LOAD: begin
				k = bins_loaded;
				// a full table drops the load
				if (k < MAX_BINS) begin
					pa = 0;
					pb = 0;
					sa = 0;
					sb = 0;
					n  = 0;
					if (k > 0) begin
						pa = rw_prefix_a[k-1];
						pb = rw_prefix_b[k-1];
						sa = w_prefix_a[k-1];
						sb = w_prefix_b[k-1];
						n  = n_prefix[k-1];
					end
					if (it.ra != 0 && it.rb != 0 && it.wa != 0 && it.wb != 0) begin
						pa += 64'(it.ra) * 64'(it.wa);
						pb += 64'(it.rb) * 64'(it.wb);
						sa += 64'(it.wa);
						sb += 64'(it.wb);
						n  += 1;
					end
					rw_prefix_a[k] = pa;
					rw_prefix_b[k] = pb;
					w_prefix_a[k]  = sa;
					w_prefix_b[k]  = sb;
					n_prefix[k]    = n;
					bins_loaded    = k + 1;
				end
			end
			OP_RESTART: bins_loaded = 0;
			OP_QUERY: begin
				has = 1'b1;
				ans = window_answer(it.bin);
			end
			default: ;
		endcase
	endfunction

	// Rate or weight: zeros, ones, full scale and small values show up often.
	function automatic logic [RATE_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 15)
			return FULL_RATE;
		if (r < 20)
			return RATE_BITS'(1);
		if (r < 35)
			return RATE_BITS'($urandom_range(1, 255));
		return RATE_BITS'($urandom);
	endfunction

	// Mostly bins that are loaded, with the range edges, zero and the whole
	// 11-bit space mixed in.
	function automatic logic [BIN_BITS-1:0] pick_query_bin();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 70)
			v = $urandom_range(1, bins_loaded + 1);
		else if (r < 85)
			v = ((r % 2) ? first_cfg : last_cfg) + $urandom_range(0, 2) - 1;
		else if (r < 92)
			v = 0;
		else
			v = $urandom_range(0, 2047);
		if (v < 0)
			v = 0;
		return BIN_BITS'(v);
	endfunction

	function automatic bin_item_t random_item();
		bin_item_t it;
		int        r;
		// fill every field so the ignored ones carry noise too
		it.bin = BIN_BITS'($urandom);
		it.ra  = pick_value();
		it.rb  = pick_value();
		it.wa  = pick_value();
		it.wb  = pick_value();
		r = $urandom_range(0, 99);
		if (r < 3)
			it.op = OP_RESTART;
		else if (r < 6)
			it.op = OP_UNUSED;
		else if (r < 55)
			it.op = OP_LOAD;
		else begin
			it.op  = OP_QUERY;
			it.bin = pick_query_bin();
		end
		return it;
	endfunction

	// Offer one transaction, hold it until accepted, then record what it should
	// produce. Entered and left just after a falling edge.
	task automatic offer(input bin_item_t it, input logic typed, input answer_t typed_ans);
		logic    has;
		answer_t ans;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		operation = it.op;
		query_bin = it.bin;
		rate_a    = it.ra;
		rate_b    = it.rb;
		weight_a  = it.wa;
		weight_b  = it.wb;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict(it, has, ans);
		if (has)
			expected_answers = {expected_answers, typed ? typed_ans : ans};
		@(negedge clk);
	endtask

	// Drop valid, wait for every answer, then let in-flight loads finish.
	task automatic wait_quiet();
		in_valid = 1'b0;
		while (expected_answers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input int value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = CDATA_BITS'(value);
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			CFG_HALF_WINDOW: hw_cfg    = value & ((1 << HW_BITS) - 1);
			CFG_FIRST_BIN:   first_cfg = value & ((1 << BIN_BITS) - 1);
			CFG_LAST_BIN:    last_cfg  = value & ((1 << BIN_BITS) - 1);
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int hw, input int first, input int last);
		wait_quiet();
		write_reg(CFG_HALF_WINDOW, hw);
		write_reg(CFG_FIRST_BIN, first);
		write_reg(CFG_LAST_BIN, last);
	endtask

	task automatic report(input string why, input answer_t want, input answer_t got);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t: %s: expected bin %0d avg_a %h avg_b %h valid %b count %0d",
				$realtime, why, want.bin, want.avg_a, want.avg_b, want.ok, want.cnt);
			$display("%0t: %s: got bin %0d avg_a %h avg_b %h valid %b count %0d",
				$realtime, why, got.bin, got.avg_a, got.avg_b, got.ok, got.cnt);
		end
		mismatches++;
	endtask

	// Receiver: random stalls, plus a long hold-off whenever the sender asks
	// for one. The hold-off is counted here so the sender keeps pushing.
	initial begin : receiver
		int hold_left;
		int served;
		hold_left = 0;
		served    = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served    = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else
				out_stall = ($urandom_range(0, 99) < recv_gap_pct);
		end
	end

	// Compare every accepted result transaction with the oldest answer waiting.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got_answer = {result_bin, average_a, average_b, valid_res, contributors};
			if (expected_answers.size() == 0)
				report("result with none pending", NO_ANSWER, got_answer);
			else begin
				want_answer = expected_answers.pop_front();
				if (got_answer.bin !== want_answer.bin || got_answer.avg_a !== want_answer.avg_a
						|| got_answer.avg_b !== want_answer.avg_b
						|| got_answer.ok !== want_answer.ok || got_answer.cnt !== want_answer.cnt)
					report("result mismatch", want_answer, got_answer);
			end
		end
	end

	// Watchdog: end the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles = 0;
		else if ((in_valid === 1'b1 && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bin_item_t it;
		// drive every input to a known value before reset
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		operation     = OP_LOAD;
		query_bin     = '0;
		rate_a        = '0;
		rate_b        = '0;
		weight_a      = '0;
		weight_b      = '0;
		mismatches    = 0;
		hold_requests = 0;
		quiet_cycles  = 0;
		bins_loaded   = 0;
		hw_cfg        = int'(HALF_WINDOW_RST);
		first_cfg     = int'(FIRST_BIN_RST);
		last_cfg      = int'(LAST_BIN_RST);
		send_gap_pct  = 15;
		recv_gap_pct  = 86;

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table at the reset settings
		for (int i = 0; i < SCRIPT_ROWS; i++)
			offer(script[i].item, script[i].typed, script[i].answer);

		for (int p = 0; p < PHASES; p++) begin
			// idle pattern: slow receiver, then slow sender, then full speed
			if (p < 4) begin
				send_gap_pct = 15;
				recv_gap_pct = 86;
			end else if (p < 8) begin
				send_gap_pct = 86;
				recv_gap_pct = 15;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end

			// last phase: a fresh random setting
			if (p == PHASES - 1) begin
				phase_hw[p]    = $urandom_range(0, 1023);
				phase_first[p] = $urandom_range(1, 64);
				phase_last[p]  = $urandom_range(phase_first[p], 1024);
			end
			apply_setting(phase_hw[p], phase_first[p], phase_last[p]);

			for (int i = 0; i < PHASE_ITEMS; i++)
				offer(random_item(), 1'b0, NO_ANSWER);

			// fill the table past capacity, then query it under wide and
			// narrow settings; the next phase starts with a full table
			if (p == 7) begin
				it = '0;
				it.op = OP_RESTART;
				offer(it, 1'b0, NO_ANSWER);
				for (int i = 0; i < FILL_LOADS; i++) begin
					it.op  = OP_LOAD;
					it.bin = BIN_BITS'($urandom);
					it.ra  = pick_value();
					it.rb  = pick_value();
					it.wa  = pick_value();
					it.wb  = pick_value();
					offer(it, 1'b0, NO_ANSWER);
				end
				for (int s = 0; s < FULL_SETTINGS; s++) begin
					apply_setting(full_hw[s], full_first[s], full_last[s]);
					for (int i = 0; i < 12; i++) begin
						// hold the receiver off while queries keep coming
						if (s == 0 && i == 1)
							hold_requests++;
						it.op  = OP_QUERY;
						it.bin = (i == 0) ? BIN_BITS'(MAX_BINS) : pick_query_bin();
						offer(it, 1'b0, NO_ANSWER);
					end
				end
			end
		end

		wait_quiet();
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
